// ===== rtl/core/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;

  localparam int MAX_BONES_DEF  = 64;
  localparam int INFLUENCES_DEF = 4;
  localparam int ELEMS          = 12;
  localparam int ROWS           = 3;
  localparam int PROD_W         = 48;
  localparam int LO_W           = 24;
  localparam int RECIP_12       = 683;
  localparam int RECIP_SH       = 13;
  localparam int PS_RESET       = 64;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_DIR   = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         palette_slot;
    logic signed [31:0] palette_value;
    logic [31:0]        bone_indices;
    logic [63:0]        weight_set;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } lbs_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } lbs_out_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  bone;
    logic [3:0]  elem;
    logic [31:0] value;
  } lbs_wr_t;

  function automatic logic is_diag(input int e);
    return (e == 0) || (e == 4) || (e == 8);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lbs_lane.sv =====
`default_nettype none
module lbs_lane import lbs_pkg::*; #(
  parameter int MAX_BONES = MAX_BONES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     adv,
  input  wire lbs_wr_t                  wr,
  input  wire logic [7:0]               rd_bone,
  input  wire logic [15:0]              weight,
  input  wire logic [6:0]               palette_size,
  output logic signed [PROD_W-1:0]      prod_r [ELEMS]
);

  localparam int BONE_AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

  logic               id_r;
  logic [15:0]        w_r;
  logic               id_nxt;
  logic [BONE_AW-1:0] raddr;
  logic [BONE_AW-1:0] waddr;

  assign raddr  = rd_bone[BONE_AW-1:0];
  assign waddr  = wr.bone[BONE_AW-1:0];
  assign id_nxt = !(({1'b0, rd_bone} < {2'b0, palette_size}) &&
                    ({1'b0, rd_bone} < 9'(MAX_BONES)));

  always_ff @(posedge clk) begin
    if (adv) begin
      id_r <= id_nxt;
      w_r  <= weight;
    end
  end

  for (genvar e = 0; e < ELEMS; e++) begin : g_elem
    logic signed [31:0] mem [MAX_BONES];
    logic signed [31:0] rd_r;

    always_ff @(posedge clk) begin
      if (wr.we && (wr.elem == 4'(e))) begin
        mem[waddr] <= wr.value;
      end
      if (adv) begin
        rd_r <= mem[raddr];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (id_r) begin
          prod_r[e] <= is_diag(e) ? PROD_W'({w_r, 16'h0000}) : '0;
        end else begin
          prod_r[e] <= PROD_W'($signed({1'b0, w_r}) * rd_r);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lbs_merge.sv =====
`default_nettype none
module lbs_merge import lbs_pkg::*; #(
  parameter int INFLUENCES = INFLUENCES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic                     s2_valid,
  input  wire logic                     s2_point,
  input  wire logic signed [31:0]       s2_vec [ROWS],
  input  wire logic signed [PROD_W-1:0] prods [INFLUENCES][ELEMS],
  output logic                          out_valid_r,
  output lbs_out_t                      out_item_r
);

  localparam int BLEND_W = PROD_W + $clog2(INFLUENCES) + 1;
  localparam int HI_W    = BLEND_W - LO_W;
  localparam int TERM_W  = BLEND_W + 32;
  localparam int ACC_W   = TERM_W + 3;
  localparam int SH_W    = ACC_W - 31;

  logic                      v3_r, v4_r, v5_r, v6_r;
  logic                      pt3_r, pt4_r, pt5_r;
  logic signed [31:0]        vec3_r [ROWS];
  logic signed [BLEND_W-1:0] blend_r [ELEMS];
  logic signed [BLEND_W-1:0] blend_nxt [ELEMS];
  logic signed [LO_W+32:0]   pl_r [9];
  logic signed [HI_W+31:0]   ph_r [9];
  logic signed [TERM_W-1:0]  tr4_r [ROWS];
  logic signed [TERM_W-1:0]  tr5_r [ROWS];
  logic signed [TERM_W-1:0]  term_r [9];
  logic signed [ACC_W-1:0]   acc_r [ROWS];
  lbs_out_t                  out_nxt;

  always_comb begin
    for (int e = 0; e < ELEMS; e++) begin
      blend_nxt[e] = '0;
      for (int i = 0; i < INFLUENCES; i++) begin
        blend_nxt[e] = blend_nxt[e] + BLEND_W'(prods[i][e]);
      end
    end
  end

  always_comb begin
    logic [SH_W-1:0]  sh;
    logic [31:0]      res [ROWS];
    logic             sat;
    sat = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      sh = acc_r[r][ACC_W-1:31];
      if ((&sh[SH_W-1:31]) || !(|sh[SH_W-1:31])) begin
        res[r] = sh[31:0];
      end else begin
        res[r] = sh[SH_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat    = 1'b1;
      end
    end
    out_nxt.out_x     = res[0];
    out_nxt.out_y     = res[1];
    out_nxt.out_z     = res[2];
    out_nxt.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blend_r <= blend_nxt;
      vec3_r  <= s2_vec;
      pt3_r   <= s2_point;
      pt4_r   <= pt3_r;
      pt5_r   <= pt4_r;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < ROWS; c++) begin
          pl_r[c*3+r] <= $signed({1'b0, blend_r[c*3+r][LO_W-1:0]}) * vec3_r[c];
          ph_r[c*3+r] <= $signed(blend_r[c*3+r][BLEND_W-1:LO_W]) * vec3_r[c];
          term_r[c*3+r] <= (TERM_W'(ph_r[c*3+r]) <<< LO_W) + TERM_W'(pl_r[c*3+r]);
        end
        tr4_r[r] <= pt3_r ? (TERM_W'(blend_r[9+r]) <<< 16) : '0;
        tr5_r[r] <= tr4_r[r];
        acc_r[r] <= ACC_W'(term_r[r]) + ACC_W'(term_r[3+r]) + ACC_W'(term_r[6+r])
                  + ACC_W'(tr5_r[r]) + ACC_W'(64'sh4000_0000);
      end
      out_item_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v3_r        <= s2_valid;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.saturated) |->
      (out_item_r.out_x == 32'sh7FFF_FFFF || out_item_r.out_x == 32'sh8000_0000 ||
       out_item_r.out_y == 32'sh7FFF_FFFF || out_item_r.out_y == 32'sh8000_0000 ||
       out_item_r.out_z == 32'sh7FFF_FFFF || out_item_r.out_z == 32'sh8000_0000))
    else $error("saturation flag without clamped component");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v6_r))
    else $error("result without item in last stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (v6_r == $past(v6_r)) && (v3_r == $past(v3_r)))
    else $error("pipeline moved while held");

endmodule
`default_nettype wire

// ===== rtl/core/linear_blend_skinning.sv =====
// stages: palette read, lane product, blend, partial products, terms, row sums, output
// throughput: one item per cycle unless stalled; single pipeline, one lane per influence
// each lane holds its own palette copy, so all bones are read in the same cycle
// a stalled result holds the whole pipeline; palette writes take effect at acceptance
// reset (synchronous, rst_n low) empties the pipeline and sets palette_size to 64;
// palette contents are not cleared
`default_nettype none
module linear_blend_skinning import lbs_pkg::*; #(
  parameter int MAX_BONES  = MAX_BONES_DEF,
  parameter int INFLUENCES = INFLUENCES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire lbs_in_t  in_item,
  output logic          in_stall,
  output logic          out_valid,
  output lbs_out_t      out_item,
  input  wire logic     out_stall,
  input  wire logic     cfg_we,
  input  wire logic [6:0] cfg_wdata
);

  localparam int STORE_DEPTH = MAX_BONES * ELEMS;

  logic               adv;
  logic               accept;
  logic               skin;
  logic [6:0]         psize_r;
  logic               v1_r, v2_r;
  logic               pt1_r, pt2_r;
  logic signed [31:0] vec1_r [ROWS];
  logic signed [31:0] vec2_r [ROWS];
  logic [19:0]        quot;
  logic [7:0]         wbone;
  logic [9:0]         wrem;
  lbs_wr_t            wr;
  logic               out_valid_r;
  lbs_out_t           out_item_r;
  logic signed [PROD_W-1:0] prods [INFLUENCES][ELEMS];

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign skin     = (in_item.opcode == OP_POINT) || (in_item.opcode == OP_DIR);

  // slot / 12 by reciprocal
  assign quot     = 20'(in_item.palette_slot * 10'(RECIP_12));
  assign wbone    = {1'b0, quot[RECIP_SH+6:RECIP_SH]};
  assign wrem     = 10'(in_item.palette_slot - 10'(wbone) * 10'(ELEMS));
  assign wr.we    = accept && (in_item.opcode == OP_WRITE) &&
                    ({2'b0, in_item.palette_slot} < 12'(STORE_DEPTH));
  assign wr.bone  = wbone;
  assign wr.elem  = wrem[3:0];
  assign wr.value = in_item.palette_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r <= 7'(PS_RESET);
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        psize_r <= cfg_wdata;
      end
      if (adv) begin
        v1_r <= accept && skin;
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt1_r     <= (in_item.opcode == OP_POINT);
      pt2_r     <= pt1_r;
      vec1_r[0] <= in_item.in_x;
      vec1_r[1] <= in_item.in_y;
      vec1_r[2] <= in_item.in_z;
      vec2_r    <= vec1_r;
    end
  end

  for (genvar i = 0; i < INFLUENCES; i++) begin : g_lane
    logic [7:0]  bone;
    logic [15:0] wgt;
    if (i < 4) begin : g_used
      assign bone = in_item.bone_indices[8*i +: 8];
      assign wgt  = in_item.weight_set[16*i +: 16];
    end else begin : g_spare
      assign bone = 8'hFF;
      assign wgt  = 16'h0000;
    end
    lbs_lane #(.MAX_BONES(MAX_BONES)) u_lane (
      .clk          (clk),
      .adv          (adv),
      .wr           (wr),
      .rd_bone      (bone),
      .weight       (wgt),
      .palette_size (psize_r),
      .prod_r       (prods[i])
    );
  end

  lbs_merge #(.INFLUENCES(INFLUENCES)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .s2_valid    (v2_r),
    .s2_point    (pt2_r),
    .s2_vec      (vec2_r),
    .prods       (prods),
    .out_valid_r (out_valid_r),
    .out_item_r  (out_item_r)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input held without a waiting result");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result right after reset");

  a_write_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && wr.we) |=> !v1_r)
    else $error("palette write entered the pipeline");

endmodule
`default_nettype wire

// ===== test/tb_linear_blend_skinning.sv =====
`timescale 1ns / 100ps
module tb_linear_blend_skinning;
  import lbs_pkg::*;

  localparam int STORE_DEPTH = MAX_BONES_DEF * ELEMS;
  localparam int STALL_LIMIT = 5000;
  localparam int LOW_BONES   = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  lbs_in_t  in_item;
  logic     in_stall;
  logic     out_valid;
  lbs_out_t out_item;
  logic     out_stall;
  logic     cfg_we;
  logic [6:0] cfg_wdata;

  logic [31:0] palette_copy [STORE_DEPTH];
  logic [6:0]  bone_limit;
  lbs_out_t    pending_vertices[$];
  logic        no_idle;
  int          n_errors;
  int          n_skinned;
  int          n_sat;
  int          n_sent;
  int          quiet_cycles;

  linear_blend_skinning i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_stall(out_stall),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic lbs_out_t skin_vertex(input lbs_in_t it);
    longint blend [ELEMS];
    logic signed [127:0] acc, bl, vv, q;
    logic signed [31:0] vec [3];
    logic [7:0] bone;
    longint w, m;
    logic [31:0] comp [3];
    logic sat;
    lbs_out_t r;
    sat = 1'b0;
    for (int e = 0; e < ELEMS; e++) blend[e] = 0;
    for (int i = 0; i < 4; i++) begin
      bone = it.bone_indices[8*i +: 8];
      w = longint'(it.weight_set[16*i +: 16]);
      for (int e = 0; e < ELEMS; e++) begin
        if (bone < bone_limit && bone < MAX_BONES_DEF) begin
          m = longint'($signed(palette_copy[bone*ELEMS + e]));
        end else begin
          m = (e / 3 == e % 3) ? 65536 : 0;
        end
        blend[e] += w * m;
      end
    end
    vec[0] = it.in_x;
    vec[1] = it.in_y;
    vec[2] = it.in_z;
    for (int rw = 0; rw < 3; rw++) begin
      acc = 0;
      for (int c = 0; c < 3; c++) begin
        bl = blend[c*3 + rw];
        vv = vec[c];
        acc += bl * vv;
      end
      if (it.opcode == OP_POINT) begin
        bl = blend[9 + rw];
        acc += bl * 65536;
      end
      acc += 128'sd1 <<< 30;
      q = acc >>> 31;
      if (q > 128'sh7FFFFFFF) begin
        comp[rw] = 32'h7FFFFFFF;
        sat = 1'b1;
      end else if (q < -128'sh80000000) begin
        comp[rw] = 32'h80000000;
        sat = 1'b1;
      end else begin
        comp[rw] = q[31:0];
      end
    end
    r.out_x = comp[0];
    r.out_y = comp[1];
    r.out_z = comp[2];
    r.saturated = sat;
    return r;
  endfunction

  task automatic send_item(input lbs_in_t it);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (it.opcode == OP_WRITE) begin
      if (it.palette_slot < STORE_DEPTH) palette_copy[it.palette_slot] = it.palette_value;
    end else if (it.opcode == OP_POINT || it.opcode == OP_DIR) begin
      pending_vertices = {pending_vertices, skin_vertex(it)};
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_bone_limit(input logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    bone_limit = v;
    cfg_we <= 1'b0;
  endtask

  function automatic lbs_in_t skin_item(input logic [1:0] op, input logic [31:0] bones,
                                        input logic [63:0] w, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
    lbs_in_t it;
    it = '0;
    it.palette_slot = 10'($urandom());
    it.palette_value = $urandom();
    it.opcode = op;
    it.bone_indices = bones;
    it.weight_set = w;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    return it;
  endfunction

  function automatic lbs_in_t write_item(input logic [9:0] slot, input logic [31:0] v);
    lbs_in_t it;
    it = skin_item(OP_WRITE, $urandom(), {$urandom(), $urandom()}, $urandom(), $urandom(),
                   $urandom());
    it.palette_slot = slot;
    it.palette_value = v;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord;
    case ($urandom_range(3))
      0: rand_coord = $urandom();
      1: rand_coord = $urandom_range(0, 32'h7FFFF) - 32'h40000;
      2: rand_coord = $urandom_range(0, 32'h3FFFFFF) - 32'h2000000;
      default: rand_coord = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  // only loaded bones or bones that always fall back to identity
  function automatic logic [7:0] rand_bone;
    case ($urandom_range(3))
      0: rand_bone = 8'(MAX_BONES_DEF - 1);
      1: rand_bone = 8'($urandom_range(LOW_BONES - 1));
      2: rand_bone = 8'($urandom_range(LOW_BONES - 1));
      default: rand_bone = 8'($urandom_range(MAX_BONES_DEF, 255));
    endcase
  endfunction

  function automatic lbs_in_t rand_item;
    int pick;
    logic [1:0] op;
    pick = $urandom_range(99);
    if (pick < 20) return write_item(10'($urandom_range(1023)), rand_coord());
    if (pick < 27) begin
      op = OP_UNUSED;
      return skin_item(op, $urandom(), {$urandom(), $urandom()}, $urandom(), $urandom(),
                       $urandom());
    end
    op = $urandom_range(1) ? OP_POINT : OP_DIR;
    return skin_item(op, {rand_bone(), rand_bone(), rand_bone(), rand_bone()},
                     {$urandom(), $urandom()}, rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic test_palette_load;
    for (int s = 0; s < LOW_BONES * ELEMS; s++) begin
      send_item(write_item(10'(s), $urandom_range(0, 32'h3FFFF) - 32'h20000));
    end
    for (int s = STORE_DEPTH - ELEMS; s < STORE_DEPTH; s++) begin
      send_item(write_item(10'(s), $urandom_range(0, 32'h3FFFF) - 32'h20000));
    end
  endtask

  task automatic test_directed;
    send_item(skin_item(OP_POINT, 32'h03020100, 64'h2000200020002000, 32'h00010000,
                        32'hFFFF0000, 32'h00008000));
    send_item(skin_item(OP_DIR, 32'h03020100, 64'h2000200020002000, 32'h00010000,
                        32'hFFFF0000, 32'h00008000));
    send_item(skin_item(OP_POINT, 32'hFFFEFDFC, 64'hFFFFFFFFFFFFFFFF, 32'h7FFFFFFF,
                        32'h80000000, 32'h7FFFFFFF));
    send_item(skin_item(OP_DIR, 32'h403F4041, 64'h8000000000000000, 32'h80000000,
                        32'h80000000, 32'h80000000));
    send_item(skin_item(OP_POINT, 32'h3F3F3F3F, 64'h0, 32'h12345678, 32'h0, 32'h1));
    send_item(skin_item(OP_POINT, 32'h00000000, 64'h0000000000008000, 32'h0, 32'h0, 32'h0));
    send_item(write_item(10'd0, 32'h7FFFFFFF));
    send_item(write_item(10'd4, 32'h80000000));
    send_item(write_item(10'd9, 32'h7FFFFFFF));
    send_item(skin_item(OP_POINT, 32'h00000000, 64'hFFFFFFFFFFFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h7FFFFFFF));
    send_item(skin_item(OP_DIR, 32'h00000000, 64'h000000000000FFFF, 32'h80000000,
                        32'h80000000, 32'h80000000));
    send_item(write_item(10'd768, 32'hDEADBEEF));
    send_item(write_item(10'd1023, 32'h12345678));
    send_item(skin_item(OP_UNUSED, 32'h0, 64'hFFFF, 32'h10000, 32'h10000, 32'h10000));
    send_item(skin_item(OP_POINT, 32'h00000000, 64'h0000000000000001, 32'h00000001,
                        32'hFFFFFFFF, 32'h0));
    send_item(write_item(10'd0, 32'h00010000));
    send_item(write_item(10'd4, 32'h00010000));
    send_item(write_item(10'd9, 32'h0));
    // sender holds off until the pipeline is empty
    drain();
    set_bone_limit(7'd0);
    send_item(skin_item(OP_POINT, 32'h01000203, 64'h4000400040004000, 32'h00030000,
                        32'hFFFD0000, 32'h7FFFFFFF));
    send_item(skin_item(OP_DIR, 32'h01000203, 64'hFFFFFFFFFFFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h80000000));
    set_bone_limit(7'd127);
    send_item(skin_item(OP_POINT, 32'h4040403F, 64'h1234567800010000, 32'h00010000,
                        32'h00020000, 32'h00030000));
  endtask

  task automatic test_random;
    logic [6:0] limits [6];
    limits = '{7'd64, 7'd1, 7'd33, 7'd0, 7'd127, 7'd64};
    for (int ph = 0; ph < 6; ph++) begin
      set_bone_limit(limits[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < 120; n++) send_item(rand_item());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    n_errors = 0;
    n_skinned = 0;
    n_sat = 0;
    n_sent = 0;
    bone_limit = 7'd64;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_palette_load();
    test_directed();
    test_random();
    drain();
    $display("%0d items sent, %0d vertices skinned, %0d of them clamped", n_sent, n_skinned,
             n_sat);
    $display("bone limits 0, 1, 33, 64 and 127 with random stalls on both channels");
    if (n_errors == 0) begin
      $display("tb_linear_blend_skinning: clean");
    end else begin
      $display("tb_linear_blend_skinning: errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= (!no_idle && $urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    lbs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        $display("%t unexpected vertex %h", $time, out_item);
        n_errors++;
      end else begin
        want = pending_vertices.pop_front();
        n_skinned++;
        if (want.saturated) n_sat++;
        if (out_item.out_x !== want.out_x) begin
          $display("%t out_x expected %h actual %h", $time, want.out_x, out_item.out_x);
          n_errors++;
        end
        if (out_item.out_y !== want.out_y) begin
          $display("%t out_y expected %h actual %h", $time, want.out_y, out_item.out_y);
          n_errors++;
        end
        if (out_item.out_z !== want.out_z) begin
          $display("%t out_z expected %h actual %h", $time, want.out_z, out_item.out_z);
          n_errors++;
        end
        if (out_item.saturated !== want.saturated) begin
          $display("%t saturated expected %b actual %b", $time, want.saturated,
                   out_item.saturated);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%t watchdog expired with %0d vertices pending", $time,
                 pending_vertices.size());
        $display("tb_linear_blend_skinning: errors");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
rtl/core/lbs_pkg.sv
rtl/core/lbs_lane.sv
rtl/core/lbs_merge.sv
rtl/core/linear_blend_skinning.sv
test/tb_linear_blend_skinning.sv
